FILE: design/mcm_pkg.sv
// Shared constants and codes for the multiset count and mode block.
package mcm_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 16;
   localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_COUNT  = 2'd1,
      CMD_MODE   = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

endpackage

FILE: design/mcm_ram.sv
// Single-port-write, registered-read memory holding the stored entries.
module mcm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/multiset_count_and_mode.sv
// Top level: bounded multiset store with occurrence count and running mode.
//
// Usage:
//  - Command channel: drive req_cmd and req_item_value with start high; the
//    beat is taken at a rising edge where start is high and busy is low.
//  - Result channel: one beat per command, shown for one cycle with
//    rsp_valid high. The receiver cannot stall; it must take the beat then.
//  - Add and count walk the stored entries through the memory read port,
//    one entry a cycle; busy holds until the result shows.
//  - Most common, add to a full store and the unused code answer in the
//    cycle after the command beat; busy does not rise for them. The mode is kept
//    up to date on each add (count of the value, index of its first copy),
//    so no walk is needed to answer it.
//  - After an add or count no new command is taken until busy falls;
//    the other commands can be taken one per cycle.
//  - Reset (synchronous, active high) empties the store at once; the
//    memory contents are not cleared, and only entries below the fill level
//    are ever read.
module multiset_count_and_mode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_cmd,
   input  logic [mcm_pkg::DATA_WIDTH-1:0] req_item_value,
   output logic                           rsp_valid,
   output logic [mcm_pkg::CNT_W-1:0]      rsp_occurrences,
   output logic [mcm_pkg::DATA_WIDTH-1:0] rsp_mode_value,
   output logic [1:0]                     rsp_status
);
   import mcm_pkg::*;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type             state_ff,  state_in;
   cmd_type               cmd_ff,    cmd_in;
   logic [DATA_WIDTH-1:0] value_ff,  value_in;
   logic [CNT_W-1:0]      fill_ff,   fill_in;
   logic [CNT_W-1:0]      issue_ff,  issue_in;
   logic                  pend_ff,   pend_in;
   logic [ADDR_W-1:0]     pidx_ff,   pidx_in;
   logic [CNT_W-1:0]      count_ff,  count_in;
   logic                  found_ff,  found_in;
   logic [ADDR_W-1:0]     first_ff,  first_in;
   logic [CNT_W-1:0]      bestn_ff,  bestn_in;
   logic [ADDR_W-1:0]     bestf_ff,  bestf_in;
   logic [DATA_WIDTH-1:0] bestv_ff,  bestv_in;
   logic                  rvalid_ff, rvalid_in;
   logic [CNT_W-1:0]      rocc_ff,   rocc_in;
   logic [DATA_WIDTH-1:0] rmode_ff,  rmode_in;
   status_type            rstat_ff,  rstat_in;

   logic                  rd_en;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  wr_en;
   logic                  match;
   logic                  full;
   logic [CNT_W-1:0]      new_n;
   logic [ADDR_W-1:0]     new_first;

   assign full  = (fill_ff == CNT_W'(CAPACITY));
   assign rd_en = (state_ff == ST_WALK) && (issue_ff < fill_ff);
   assign match = pend_ff && (rd_data == value_ff);
   // A value never seen before gets its first copy at the fill position.
   assign new_n     = count_ff + CNT_W'(1);
   assign new_first = found_ff ? first_ff : fill_ff[ADDR_W-1:0];

   mcm_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH),
      .AW    (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      value_in  = value_ff;
      fill_in   = fill_ff;
      issue_in  = issue_ff;
      pend_in   = 1'b0;
      pidx_in   = issue_ff[ADDR_W-1:0];
      count_in  = count_ff;
      found_in  = found_ff;
      first_in  = first_ff;
      bestn_in  = bestn_ff;
      bestf_in  = bestf_ff;
      bestv_in  = bestv_ff;
      rvalid_in = 1'b0;
      rocc_in   = '0;
      rmode_in  = '0;
      rstat_in  = STATUS_OK;
      wr_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(req_cmd);
               value_in = req_item_value;
               issue_in = '0;
               count_in = '0;
               found_in = 1'b0;
               first_in = '0;
               case (cmd_type'(req_cmd))
                  CMD_ADD: begin
                     if (full) begin
                        rvalid_in = 1'b1;
                        rstat_in  = STATUS_FULL;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  CMD_COUNT: begin
                     state_in = ST_WALK;
                  end
                  CMD_MODE: begin
                     rvalid_in = 1'b1;
                     if (fill_ff == '0) begin
                        rstat_in = STATUS_EMPTY;
                     end else begin
                        rmode_in = bestv_ff;
                     end
                  end
                  default: begin
                     rvalid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // advance the read pointer; compare the beat read last cycle
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
               pend_in  = 1'b1;
            end
            if (match) begin
               count_in = count_ff + CNT_W'(1);
               if (!found_ff) begin
                  found_in = 1'b1;
                  first_in = pidx_ff;
               end
            end
            if (!rd_en && !pend_ff) begin
               state_in  = ST_IDLE;
               rvalid_in = 1'b1;
               if (cmd_ff == CMD_ADD) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + CNT_W'(1);
                  // earlier first copy wins a tie
                  if ((new_n > bestn_ff) ||
                      ((new_n == bestn_ff) && (new_first < bestf_ff))) begin
                     bestn_in = new_n;
                     bestf_in = new_first;
                     bestv_in = value_ff;
                  end
               end else begin
                  rocc_in = count_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         pend_ff   <= 1'b0;
         bestn_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         pend_ff   <= pend_in;
         bestn_ff  <= bestn_in;
         rvalid_ff <= rvalid_in;
      end
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      issue_ff <= issue_in;
      pidx_ff  <= pidx_in;
      count_ff <= count_in;
      found_ff <= found_in;
      first_ff <= first_in;
      bestf_ff <= bestf_in;
      bestv_ff <= bestv_in;
      rocc_ff  <= rocc_in;
      rmode_ff <= rmode_in;
      rstat_ff <= rstat_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rvalid_ff;
   assign rsp_occurrences = rocc_ff;
   assign rsp_mode_value  = rmode_ff;
   assign rsp_status      = rstat_ff;

endmodule

FILE: design/mcm_checker.sv
// Port-level checks for the multiset count and mode block, bound to the top.
module mcm_port_checks (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [1:0]                     req_cmd,
   input logic [mcm_pkg::DATA_WIDTH-1:0] req_item_value,
   input logic                           rsp_valid,
   input logic [mcm_pkg::CNT_W-1:0]      rsp_occurrences,
   input logic [mcm_pkg::DATA_WIDTH-1:0] rsp_mode_value,
   input logic [1:0]                     rsp_status
);
   import mcm_pkg::*;

   // an accepted beat either keeps the block busy or answers next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command neither started work nor answered");

   // a walk always ends with its answer
   a_walk_answers: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("walk ended without a result");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_EMPTY || rsp_status == STATUS_FULL))
         |-> (rsp_occurrences == '0 && rsp_mode_value == '0))
      else $error("error status carries nonzero payload");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STATUS_RSVD))
      else $error("reserved status code on result");

endmodule

bind multiset_count_and_mode mcm_port_checks u_mcm_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_cmd         (req_cmd),
   .req_item_value  (req_item_value),
   .rsp_valid       (rsp_valid),
   .rsp_occurrences (rsp_occurrences),
   .rsp_mode_value  (rsp_mode_value),
   .rsp_status      (rsp_status)
);

FILE: tb/sv/mcm_checker.sv
// Scoreboard for the multiset block: mirrors the store, predicts each response beat and compares.
module mcm_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [1:0]                     req_cmd,
   input  logic [mcm_pkg::DATA_WIDTH-1:0] req_item_value,
   input  logic                           rsp_valid,
   input  logic [mcm_pkg::CNT_W-1:0]      rsp_occurrences,
   input  logic [mcm_pkg::DATA_WIDTH-1:0] rsp_mode_value,
   input  logic [1:0]                     rsp_status,
   output int                             fail_count,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import mcm_pkg::*;

   typedef struct packed {
      logic [CNT_W-1:0]      occurrences;
      logic [DATA_WIDTH-1:0] mode_value;
      status_type            status;
   } answer_type;

   logic [DATA_WIDTH-1:0] held_values [CAPACITY];
   int                    held_count;
   answer_type            expected_answers [$];

   function automatic int tally_of(logic [DATA_WIDTH-1:0] v);
      int n;
      n = 0;
      for (int i = 0; i < held_count; i++) begin
         if (held_values[i] == v) n++;
      end
      return n;
   endfunction

   function automatic answer_type predict_answer(cmd_type c, logic [DATA_WIDTH-1:0] v);
      answer_type a;
      int         best_n;
      int         n;
      a = '{occurrences: '0, mode_value: '0, status: STATUS_OK};
      case (c)
         CMD_ADD: begin
            if (held_count >= CAPACITY) begin
               a.status = STATUS_FULL;
            end else begin
               held_values[held_count] = v;
               held_count++;
            end
         end
         CMD_COUNT: begin
            a.occurrences = CNT_W'(tally_of(v));
         end
         CMD_MODE: begin
            if (held_count == 0) begin
               a.status = STATUS_EMPTY;
            end else begin
               // strict greater keeps the earliest stored value on a tie
               best_n       = tally_of(held_values[0]);
               a.mode_value = held_values[0];
               for (int i = 1; i < held_count; i++) begin
                  n = tally_of(held_values[i]);
                  if (n > best_n) begin
                     best_n       = n;
                     a.mode_value = held_values[i];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type exp_a;
      answer_type got_a;
      if (reset) begin
         held_count = 0;
         expected_answers.delete();
         fail_count <= 0;
      end else begin
         // take the command beat first, a same-edge response then finds it
         if (start && !busy) begin
            expected_answers.push_back(predict_answer(cmd_type'(req_cmd), req_item_value));
         end
         if (rsp_valid) begin
            got_a = '{occurrences: rsp_occurrences, mode_value: rsp_mode_value,
                      status: status_type'(rsp_status)};
            if (expected_answers.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response beat with none expected: occ=%0d mode=%h status=%0d",
                           $realtime, got_a.occurrences, got_a.mode_value, got_a.status);
               fail_count <= fail_count + 1;
            end else begin
               exp_a = expected_answers.pop_front();
               if (exp_a !== got_a) begin
                  if (fail_count < 10)
                     $display({"%0t: mismatch: expected occ=%0d mode=%h status=%0d,",
                               " got occ=%0d mode=%h status=%0d"},
                              $realtime, exp_a.occurrences, exp_a.mode_value, exp_a.status,
                              got_a.occurrences, got_a.mode_value, got_a.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= expected_answers.size();
   end

endmodule

FILE: tb/sv/tb_multiset_count_and_mode.sv
// Testbench top for the multiset block: clock, reset, command stimulus and verdict.
module tb_multiset_count_and_mode;
   timeunit 1ns;
   timeprecision 1ps;
   import mcm_pkg::*;

   localparam int RANDOM_BEATS = 1700;
   localparam int CYCLE_LIMIT  = 1000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_cmd = CMD_UNUSED;
   logic [DATA_WIDTH-1:0] req_item_value = '0;
   logic                  rsp_valid;
   logic [CNT_W-1:0]      rsp_occurrences;
   logic [DATA_WIDTH-1:0] rsp_mode_value;
   logic [1:0]            rsp_status;
   int                    fail_count;
   int                    pending;
   int                    cycle_count = 0;
   int                    idle_pct = 0;

   logic [DATA_WIDTH-1:0] value_pool [6] = '{16'h0000, 16'hFFFF, 16'h00A5,
                                             16'h8000, 16'h7FFF, 16'h1234};

   always #5 clock = ~clock;

   multiset_count_and_mode i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_occurrences (rsp_occurrences),
      .rsp_mode_value  (rsp_mode_value),
      .rsp_status      (rsp_status)
   );

   mcm_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_occurrences (rsp_occurrences),
      .rsp_mode_value  (rsp_mode_value),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Present one command beat and hold it until the block takes it.
   task automatic issue_command(cmd_type c, logic [DATA_WIDTH-1:0] v);
      start          <= 1'b1;
      req_cmd        <= c;
      req_item_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Mostly a small pool so counts and ties build up; sometimes any value.
   function automatic logic [DATA_WIDTH-1:0] pick_value();
      if ($urandom_range(99) < 70) return value_pool[$urandom_range(5)];
      return DATA_WIDTH'($urandom);
   endfunction

   function automatic cmd_type pick_command();
      int roll;
      roll = $urandom_range(99);
      if (roll < 9)  return CMD_ADD;
      if (roll < 55) return CMD_COUNT;
      if (roll < 92) return CMD_MODE;
      return CMD_UNUSED;
   endfunction

   initial begin
      int idle_by_phase [4];
      idle_by_phase = '{0, 75, 0, 15};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store, then a tie settled by first insertion
      issue_command(CMD_MODE,   16'h0000);
      issue_command(CMD_COUNT,  16'h0000);
      issue_command(CMD_COUNT,  16'hFFFF);
      issue_command(CMD_UNUSED, 16'hFFFF);
      issue_command(CMD_ADD,    16'hFFFF);
      issue_command(CMD_ADD,    16'h0000);
      issue_command(CMD_COUNT,  16'hFFFF);
      issue_command(CMD_COUNT,  16'h0000);
      issue_command(CMD_MODE,   16'hFFFF);
      issue_command(CMD_ADD,    16'h0000);
      issue_command(CMD_MODE,   16'h0000);
      issue_command(CMD_ADD,    16'hFFFF);
      issue_command(CMD_MODE,   16'h5555);
      issue_command(CMD_ADD,    16'h1234);
      issue_command(CMD_COUNT,  16'h1234);
      issue_command(CMD_COUNT,  16'hABCD);
      issue_command(CMD_UNUSED, 16'h5555);
      issue_command(CMD_UNUSED, 16'h0000);
      issue_command(CMD_MODE,   16'hAAAA);

      // store fills over the first half, later adds come back full
      for (int p = 0; p < 4; p++) begin
         idle_pct = idle_by_phase[p];
         for (int i = 0; i < RANDOM_BEATS / 4; i++)
            issue_command(pick_command(), pick_value());
      end
      start <= 1'b0;

      @(posedge clock);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
